@@ design/ccci_pkg.sv @@
// Shared types and constants for the clock chip command interface.
package ccci_pkg;

   localparam int RAM_DEPTH  = 256;
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

   localparam logic [7:0] RAM_CMD_MASK   = 8'h78;
   localparam logic [7:0] RAM_CMD_CODE   = 8'h38;
   localparam logic [7:0] CLOCK_CMD_MASK = 8'h73;
   localparam logic [7:0] CLOCK_CMD_CODE = 8'h01;

   typedef enum logic [2:0] {
      CMD_READ_DATA  = 3'd0,
      CMD_WRITE_DATA = 3'd1,
      CMD_READ_CTRL  = 3'd2,
      CMD_WRITE_CTRL = 3'd3,
      CMD_SOFT_RESET = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_ADDR = 2'd1,
      PHASE_XFER = 2'd2
   } phase_type;

endpackage

@@ design/clock_chip_command_interface_core.sv @@
// Clock chip command interface: register access, command machine and battery RAM.
//
// Every bus access produces one transfer on the result channel; a new access
// is taken every cycle while the result register is free or being drained.
// The 256-byte battery RAM is a synchronous memory with a registered read port,
// read continuously at the pending target address so
// the byte is ready when the command machine reaches its transfer phase; a
// per-byte valid bit makes the RAM read as zero after reset, so no clearing
// pass is needed. The time offset register may be written at any time; its
// ready is always high.
module clock_chip_command_interface_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_write_value,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_value,
   output logic [3:0]  rsp_border_color,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_write_data
);
   import ccci_pkg::*;

   logic [31:0]           time_offset_ff;
   logic [7:0]            data_byte_ff, data_byte_in;
   logic [3:0]            control_bits_ff, control_bits_in;
   logic [3:0]            border_ff, border_in;
   logic                  is_read_ff, is_read_in;
   logic                  is_ram_ff, is_ram_in;
   logic [RAM_ADDR_W-1:0] target_address_ff, target_address_in;
   logic [31:0]           latched_time_ff, latched_time_in;
   phase_type             phase_ff, phase_in;

   logic                  rsp_valid_ff;
   logic [7:0]            read_value_ff, read_value_in;
   logic [3:0]            border_out_ff;

   logic [7:0]            battery_ram [RAM_DEPTH];
   logic [RAM_DEPTH-1:0]  ram_valid_ff;
   logic [7:0]            ram_rd_data_ff;
   logic                  ram_rd_valid_ff;
   logic                  ram_we;
   logic [7:0]            ram_wr_data;

   logic                  accept;
   logic [7:0]            cmd_data;
   cmd_type               cmd;
   logic                  is_ram_cmd;
   logic                  is_clock_cmd;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_command);
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = read_value_ff;
   assign rsp_border_color = border_out_ff;

   assign cmd_data     = req_write_value[5] ? data_byte_ff : 8'h00;
   assign is_ram_cmd   = (cmd_data & RAM_CMD_MASK) == RAM_CMD_CODE;
   assign is_clock_cmd = (cmd_data & CLOCK_CMD_MASK) == CLOCK_CMD_CODE;

   // Command machine phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (cmd)
            CMD_WRITE_CTRL: begin
               unique case (phase_ff)
                  PHASE_IDLE: begin
                     if (is_ram_cmd) begin
                        phase_in = PHASE_ADDR;
                     end else if (is_clock_cmd) begin
                        phase_in = PHASE_XFER;
                     end
                  end
                  PHASE_ADDR: phase_in = PHASE_XFER;
                  default:    phase_in = PHASE_IDLE;
               endcase
            end
            CMD_SOFT_RESET: phase_in = PHASE_IDLE;
            default:        phase_in = phase_ff;
         endcase
      end
   end

   // Register updates and result value.
   always_comb begin
      data_byte_in      = data_byte_ff;
      control_bits_in   = control_bits_ff;
      border_in         = border_ff;
      is_read_in        = is_read_ff;
      is_ram_in         = is_ram_ff;
      target_address_in = target_address_ff;
      latched_time_in   = latched_time_ff;
      read_value_in     = 8'h00;
      ram_we            = 1'b0;
      ram_wr_data       = cmd_data;
      if (accept) begin
         case (cmd)
            CMD_READ_DATA:  read_value_in = data_byte_ff;
            CMD_WRITE_DATA: data_byte_in = req_write_value;
            CMD_READ_CTRL:  read_value_in = {control_bits_ff, border_ff};
            CMD_WRITE_CTRL: begin
               border_in       = req_write_value[3:0];
               control_bits_in = {1'b0, req_write_value[6:4]};
               data_byte_in    = cmd_data;
               unique case (phase_ff)
                  PHASE_IDLE: begin
                     if (is_ram_cmd) begin
                        is_ram_in         = 1'b1;
                        is_read_in        = cmd_data[7];
                        target_address_in = {cmd_data[2:0], 5'b00000};
                     end else if (is_clock_cmd) begin
                        is_ram_in         = 1'b0;
                        is_read_in        = cmd_data[7];
                        target_address_in = {6'b000000, cmd_data[3:2]};
                     end
                  end
                  PHASE_ADDR: begin
                     target_address_in = target_address_ff | {3'b000, cmd_data[6:2]};
                  end
                  PHASE_XFER: begin
                     if (is_ram_ff) begin
                        if (is_read_ff) begin
                           data_byte_in = ram_rd_valid_ff ? ram_rd_data_ff : 8'h00;
                        end else begin
                           ram_we = 1'b1;
                        end
                     end else if (is_read_ff) begin
                        if (target_address_ff[1:0] == 2'd0) begin
                           latched_time_in = req_now_seconds + time_offset_ff;
                        end
                        case (target_address_ff[1:0])
                           2'd0:    data_byte_in = latched_time_in[7:0];
                           2'd1:    data_byte_in = latched_time_in[15:8];
                           2'd2:    data_byte_in = latched_time_in[23:16];
                           default: data_byte_in = latched_time_in[31:24];
                        endcase
                     end
                     is_read_in = 1'b0;
                     is_ram_in  = 1'b0;
                  end
                  default: begin
                     is_read_in = 1'b0;
                     is_ram_in  = 1'b0;
                  end
               endcase
            end
            CMD_SOFT_RESET: begin
               data_byte_in    = 8'h00;
               control_bits_in = {2'b00, control_bits_ff[1:0]};
               is_read_in      = 1'b0;
               is_ram_in       = 1'b0;
            end
            default: read_value_in = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_offset_ff    <= 32'h0;
         data_byte_ff      <= 8'h00;
         control_bits_ff   <= 4'h0;
         border_ff         <= 4'h0;
         is_read_ff        <= 1'b0;
         is_ram_ff         <= 1'b0;
         target_address_ff <= '0;
         latched_time_ff   <= 32'h0;
         phase_ff          <= PHASE_IDLE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            time_offset_ff <= csr_write_data;
         end
         data_byte_ff      <= data_byte_in;
         control_bits_ff   <= control_bits_in;
         border_ff         <= border_in;
         is_read_ff        <= is_read_in;
         is_ram_ff         <= is_ram_in;
         target_address_ff <= target_address_in;
         latched_time_ff   <= latched_time_in;
         phase_ff          <= phase_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         border_out_ff <= border_in;
      end
   end

   // The RAM is read every cycle at the next target address; a write to the
   // same byte in the same cycle is forwarded into the read register.
   always_ff @(posedge clock) begin
      if (ram_we) begin
         battery_ram[target_address_ff] <= ram_wr_data;
      end
      if (ram_we && (target_address_ff == target_address_in)) begin
         ram_rd_data_ff <= ram_wr_data;
      end else begin
         ram_rd_data_ff <= battery_ram[target_address_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_valid_ff    <= '0;
         ram_rd_valid_ff <= 1'b0;
      end else begin
         if (ram_we) begin
            ram_valid_ff[target_address_ff] <= 1'b1;
         end
         ram_rd_valid_ff <= (ram_we && (target_address_ff == target_address_in))
                            || ram_valid_ff[target_address_in];
      end
   end

endmodule

@@ tb/sv/ccci_scoreboard_pkg.sv @@
// Scoreboard class that predicts and checks the clock chip command interface.
package ccci_scoreboard_pkg;

   import ccci_pkg::*;

   typedef struct packed {
      logic [7:0] read_value;
      logic [3:0] border_color;
   } bus_result_type;

   class ccci_scoreboard;

      logic [31:0] time_offset;
      logic [7:0]  data_byte;
      logic [3:0]  control_bits;
      phase_type   phase;
      logic        is_read;
      logic        is_ram;
      logic [7:0]  target_address;
      logic [7:0]  battery_ram [RAM_DEPTH];
      logic [31:0] latched_time;
      logic [3:0]  border_nibble;

      bus_result_type expected_results [$];
      int             mismatches;

      function new();
         time_offset    = '0;
         data_byte      = '0;
         control_bits   = '0;
         phase          = PHASE_IDLE;
         is_read        = 1'b0;
         is_ram         = 1'b0;
         target_address = '0;
         latched_time   = '0;
         border_nibble  = '0;
         mismatches     = 0;
         foreach (battery_ram[i]) battery_ram[i] = '0;
      endfunction

      function void set_offset(logic [31:0] value);
         time_offset = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void return_to_idle();
         phase   = PHASE_IDLE;
         is_read = 1'b0;
         is_ram  = 1'b0;
      endfunction

      function void write_control(logic [7:0] value, logic [31:0] now_seconds);
         logic [1:0] byte_index;
         border_nibble = value[3:0];
         control_bits  = value[7:4];
         if (!value[5]) begin
            data_byte = '0;
         end
         case (phase)
            PHASE_IDLE: begin
               if ((data_byte & RAM_CMD_MASK) == RAM_CMD_CODE) begin
                  phase          = PHASE_ADDR;
                  is_ram         = 1'b1;
                  is_read        = data_byte[7];
                  target_address = {data_byte[2:0], 5'b00000};
               end else if ((data_byte & CLOCK_CMD_MASK) == CLOCK_CMD_CODE) begin
                  phase          = PHASE_XFER;
                  is_ram         = 1'b0;
                  is_read        = data_byte[7];
                  target_address = {6'b000000, data_byte[3:2]};
               end
            end
            PHASE_ADDR: begin
               target_address = target_address | {3'b000, data_byte[6:2]};
               phase          = PHASE_XFER;
            end
            PHASE_XFER: begin
               if (is_ram) begin
                  if (is_read) begin
                     data_byte = battery_ram[target_address];
                  end else begin
                     battery_ram[target_address] = data_byte;
                  end
               end else if (is_read) begin
                  byte_index = target_address[1:0];
                  if (byte_index == 2'd0) begin
                     latched_time = now_seconds + time_offset;
                  end
                  data_byte = 8'(latched_time >> (8 * byte_index));
               end
               return_to_idle();
            end
            default: begin
               return_to_idle();
            end
         endcase
         control_bits[3] = 1'b0;
      endfunction

      function void note_access(logic [2:0] command, logic [7:0] write_value,
                                logic [31:0] now_seconds);
         bus_result_type result;
         result.read_value = '0;
         case (command)
            CMD_READ_DATA: begin
               result.read_value = data_byte;
            end
            CMD_WRITE_DATA: begin
               data_byte = write_value;
            end
            CMD_READ_CTRL: begin
               result.read_value = {control_bits, border_nibble};
            end
            CMD_WRITE_CTRL: begin
               write_control(write_value, now_seconds);
            end
            CMD_SOFT_RESET: begin
               data_byte       = '0;
               control_bits[3] = 1'b0;
               control_bits[2] = 1'b0;
               return_to_idle();
            end
            default: begin
            end
         endcase
         result.border_color = border_nibble;
         expected_results.push_back(result);
      endfunction

      function void check_result(logic [7:0] read_value, logic [3:0] border_color);
         bus_result_type wanted;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result transfer: read %02h border %1h",
                        read_value, border_color);
            end
            return;
         end
         wanted = expected_results.pop_front();
         if (read_value !== wanted.read_value || border_color !== wanted.border_color) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch: expected read %02h border %1h, got read %02h border %1h",
                        wanted.read_value, wanted.border_color, read_value, border_color);
            end
         end
      endfunction

   endclass

endpackage

@@ tb/sv/clock_chip_command_interface_core_test.sv @@
// Top-level testbench for the clock chip command interface core.
module clock_chip_command_interface_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import ccci_pkg::*;
   import ccci_scoreboard_pkg::*;

   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   localparam int         IDLE_LIMIT    = 5000;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         PHASE_ITEMS   = 255;

   typedef struct {
      logic [2:0]  command;
      logic [7:0]  write_value;
      logic [31:0] now_seconds;
   } bus_access_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [7:0]  req_write_value = '0;
   logic [31:0] req_now_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_value;
   logic [3:0]  rsp_border_color;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_write_data = '0;

   ccci_scoreboard board;
   bit             quiet = 1'b0;
   bit             hold_off_request = 1'b0;
   int             accesses_sent = 0;
   int             idle_cycles = 0;

   clock_chip_command_interface_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_write_value  (req_write_value),
      .req_now_seconds  (req_now_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_border_color (rsp_border_color),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_time();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         return 32'h0000_0000;
      end else if (roll == 1) begin
         return 32'hFFFF_FFFF;
      end
      return $urandom();
   endfunction

   function automatic bus_access_type make_access(logic [2:0] command, logic [7:0] value);
      bus_access_type access;
      access.command     = command;
      access.write_value = value;
      access.now_seconds = pick_time();
      return access;
   endfunction

   function automatic logic [7:0] control_keep_data();
      return {2'($urandom()), 1'b1, 5'($urandom())};
   endfunction

   function automatic bus_access_type make_noise();
      return make_access(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
   endfunction

   task automatic build_ram_access(ref bus_access_type seq[$], input logic read_op,
                                   input logic [7:0] address, input logic [7:0] value);
      seq.push_back(make_access(CMD_WRITE_DATA, {read_op, 4'b0111, address[7:5]}));
      seq.push_back(make_access(CMD_WRITE_CTRL, control_keep_data()));
      seq.push_back(make_access(CMD_WRITE_DATA,
                                {1'($urandom()), address[4:0], 2'($urandom())}));
      seq.push_back(make_access(CMD_WRITE_CTRL, control_keep_data()));
      if (!read_op) begin
         seq.push_back(make_access(CMD_WRITE_DATA, value));
      end
      seq.push_back(make_access(CMD_WRITE_CTRL, control_keep_data()));
      if (read_op) begin
         seq.push_back(make_access(CMD_READ_DATA, 8'($urandom())));
      end
   endtask

   task automatic build_clock_access(ref bus_access_type seq[$], input logic read_op,
                                     input logic [1:0] byte_index);
      seq.push_back(make_access(CMD_WRITE_DATA, {read_op, 3'b000, byte_index, 2'b01}));
      seq.push_back(make_access(CMD_WRITE_CTRL, control_keep_data()));
      seq.push_back(make_access(CMD_WRITE_CTRL, control_keep_data()));
      seq.push_back(make_access(CMD_READ_DATA, 8'($urandom())));
   endtask

   task automatic send_access(bus_access_type access);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= access.command;
      req_write_value <= access.write_value;
      req_now_seconds <= access.now_seconds;
      do @(posedge clock); while (req_stall);
      board.note_access(access.command, access.write_value, access.now_seconds);
      accesses_sent++;
   endtask

   task automatic send_sequence(bus_access_type seq[$]);
      foreach (seq[i]) send_access(seq[i]);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_time_offset(logic [31:0] value);
      csr_valid      <= 1'b1;
      csr_write_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_offset(value);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      bus_access_type seq[$];
      seq.push_back(make_access(CMD_READ_DATA, 8'h00));
      seq.push_back(make_access(CMD_WRITE_DATA, 8'hFF));
      seq.push_back(make_access(CMD_READ_DATA, 8'h00));
      seq.push_back(make_access(CMD_WRITE_CTRL, 8'hFF));
      seq.push_back(make_access(CMD_READ_CTRL, 8'h00));
      seq.push_back(make_access(CMD_SOFT_RESET, 8'hFF));
      seq.push_back(make_access(CMD_READ_CTRL, 8'h00));
      seq.push_back(make_access(CMD_UNUSED_LO, 8'hFF));
      seq.push_back(make_access(CMD_UNUSED_HI, 8'h00));
      build_clock_access(seq, 1'b1, 2'd0);
      build_ram_access(seq, 1'b0, 8'hFF, 8'hA5);
      build_ram_access(seq, 1'b1, 8'hFF, 8'h00);
      foreach (seq[i]) seq[i].now_seconds = 32'hFFFF_FFFF;
      send_sequence(seq);
   endtask

   task automatic run_random_sequence();
      bus_access_type seq[$];
      int             roll;
      logic [7:0]     address;
      roll    = $urandom_range(0, 99);
      address = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
      if (roll < 45) begin
         build_ram_access(seq, 1'($urandom()), address, 8'($urandom()));
      end else if (roll < 80) begin
         build_clock_access(seq, 1'($urandom()), 2'($urandom()));
      end else begin
         repeat ($urandom_range(1, 4)) seq.push_back(make_noise());
      end
      if ($urandom_range(0, 4) == 0) begin
         seq.insert($urandom_range(0, seq.size()), make_access(CMD_READ_CTRL, 8'($urandom())));
      end
      if (roll < 80 && $urandom_range(0, 6) == 0) begin
         seq[$urandom_range(0, seq.size() - 1)] = make_noise();
      end
      send_sequence(seq);
   endtask

   initial begin
      logic [31:0] offsets [6];
      offsets = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                  32'($urandom()), 32'($urandom())};
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int stage = 0; stage < 6; stage++) begin
         wait_until_drained();
         write_time_offset(offsets[stage]);
         quiet = (stage == 2);
         if (stage == 3) begin
            hold_off_request = 1'b1;
         end
         while (accesses_sent < 25 + (stage + 1) * PHASE_ITEMS) run_random_sequence();
      end
      quiet = 1'b0;
      wait_until_drained();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      int run_length;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            run_length = pick_gap();
            if (run_length > 0) begin
               rsp_stall <= 1'b1;
               repeat (run_length) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            run_length = $urandom_range(1, 20);
            repeat (run_length) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_read_value, rsp_border_color);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("no transfer for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
